>>> hw/rtl/ufea_pkg.sv
// Shared types and constants for the union-find edge acceptor.
// No dependencies; imported by every module of the block.
`default_nettype none

package ufea_pkg;

    localparam int NODES_DEF       = 1024;
    localparam int WEIGHT_BITS_DEF = 32;
    localparam int NODE_W          = 10;
    localparam int WEIGHT_W        = 32;
    localparam int SUM_W           = 48;
    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 10'd1023;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK_START,
        ST_WALK,
        ST_COMP_START,
        ST_COMP,
        ST_LINK,
        ST_OUTPUT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_WALK_START,
        DP_WALK_STEP,
        DP_COMP_START,
        DP_COMP_STEP,
        DP_LINK,
        DP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   use_b;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad;
        logic at_root;
        logic start_is_root;
        logic comp_end;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ufea_ctrl.sv
// Sequencer for the union-find edge acceptor: clearing pass, two root walks,
// up to two compression passes, link and result strobe. Depends on ufea_pkg.
`default_nettype none

module ufea_ctrl
    import ufea_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  wire dp_status_t  status,
    output dp_cmd_t          cmd,
    output logic             busy
);

    state_t state_reg, state_next;
    logic   side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        cmd.op     = DP_NOP;
        cmd.use_b  = side_reg;
        busy       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                side_next = 1'b0;
                if (status.bad)
                    state_next = ST_OUTPUT;
                else
                    state_next = ST_WALK_START;
            end
            ST_WALK_START:
            begin
                cmd.op     = DP_WALK_START;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.op = DP_WALK_STEP;
                if (status.at_root)
                    state_next = ST_COMP_START;
            end
            ST_COMP_START:
            begin
                cmd.op = DP_COMP_START;
                if (status.start_is_root)
                begin
                    // start node is its own root: nothing to compress
                    if (side_reg)
                        state_next = ST_LINK;
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = ST_WALK_START;
                    end
                end
                else
                    state_next = ST_COMP;
            end
            ST_COMP:
            begin
                cmd.op = DP_COMP_STEP;
                if (status.comp_end)
                begin
                    if (side_reg)
                        state_next = ST_LINK;
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = ST_WALK_START;
                    end
                end
            end
            ST_LINK:
            begin
                cmd.op     = DP_LINK;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                cmd.op     = DP_DONE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ufea_dpath.sv
// Datapath for the union-find edge acceptor: parent memory, walk pointer,
// roots, saturating weight sum and result registers. Depends on ufea_pkg.
`default_nettype none

module ufea_dpath
    import ufea_pkg::*;
#(
    parameter int NODES       = NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire dp_cmd_t         cmd,
    output dp_status_t           status,
    input  wire [NODE_W-1:0]     node_a,
    input  wire [NODE_W-1:0]     node_b,
    input  wire [WEIGHT_W-1:0]   edge_weight,
    input  wire                  last_edge,
    input  wire                  cfg_write,
    input  wire [NODE_W-1:0]     cfg_data,
    output logic                 done,
    output logic                 accepted,
    output logic [SUM_W-1:0]     tree_total,
    output logic                 total_final,
    output logic                 bad_node
);

    localparam int IDX_W = $clog2(NODES);
    localparam logic [63:0] WMASK64 = (64'd1 << WEIGHT_BITS) - 64'd1;
    localparam logic [WEIGHT_W-1:0] W_MASK = WMASK64[WEIGHT_W-1:0];
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    logic [IDX_W-1:0]    mem [NODES];
    logic [IDX_W-1:0]    rdata_reg;

    logic [NODE_W-1:0]   node_count_reg;
    logic [NODE_W-1:0]   a_reg, b_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic                last_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    root_a_reg, root_b_reg;
    logic [IDX_W-1:0]    clr_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                acc_reg;
    logic                done_reg, bad_out_reg, final_reg;

    logic [IDX_W-1:0]    a_idx, b_idx, start_node, root_sel, rd_addr;
    logic                a_ok, b_ok, bad;
    logic                we;
    logic [IDX_W-1:0]    wr_addr, wr_data;
    logic [SUM_W:0]      sum_ext;

    assign a_ok = (a_reg != '0) && (a_reg <= node_count_reg) && (32'(a_reg) < NODES);
    assign b_ok = (b_reg != '0) && (b_reg <= node_count_reg) && (32'(b_reg) < NODES);
    assign bad  = !(a_ok && b_ok);

    assign a_idx      = IDX_W'(a_reg);
    assign b_idx      = IDX_W'(b_reg);
    assign start_node = cmd.use_b ? b_idx : a_idx;
    assign root_sel   = cmd.use_b ? root_b_reg : root_a_reg;

    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(w_reg & W_MASK);

    assign status.clear_last    = (clr_reg == LAST_IDX);
    assign status.bad           = bad;
    assign status.at_root       = (rdata_reg == cur_reg);
    assign status.start_is_root = (start_node == root_sel);
    assign status.comp_end      = (rdata_reg == root_sel);

    // read port: the walk follows the parent just read, one step a cycle
    always_comb
    begin
        case (cmd.op)
            DP_WALK_START, DP_COMP_START: rd_addr = start_node;
            DP_WALK_STEP, DP_COMP_STEP:   rd_addr = rdata_reg;
            default:                      rd_addr = cur_reg;
        endcase
    end

    always_comb
    begin
        we      = 1'b0;
        wr_addr = cur_reg;
        wr_data = root_sel;
        case (cmd.op)
            DP_CLEAR:
            begin
                we      = 1'b1;
                wr_addr = clr_reg;
                wr_data = clr_reg;
            end
            DP_COMP_STEP:
            begin
                we      = 1'b1;
                wr_addr = cur_reg;
                wr_data = root_sel;
            end
            DP_LINK:
            begin
                we      = (root_a_reg != root_b_reg);
                wr_addr = root_a_reg;
                wr_data = root_b_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            clr_reg        <= '0;
            sum_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                node_count_reg <= cfg_data;
            if (cmd.op == DP_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.op == DP_LINK && root_a_reg != root_b_reg)
                sum_reg <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            done_reg <= (cmd.op == DP_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                a_reg    <= node_a;
                b_reg    <= node_b;
                w_reg    <= edge_weight;
                last_reg <= last_edge;
                acc_reg  <= 1'b0;
            end
            DP_WALK_START, DP_COMP_START:
            begin
                cur_reg <= start_node;
            end
            DP_WALK_STEP:
            begin
                if (rdata_reg == cur_reg)
                begin
                    if (cmd.use_b)
                        root_b_reg <= cur_reg;
                    else
                        root_a_reg <= cur_reg;
                end
                else
                    cur_reg <= rdata_reg;
            end
            DP_COMP_STEP:
            begin
                cur_reg <= rdata_reg;
            end
            DP_LINK:
            begin
                acc_reg <= (root_a_reg != root_b_reg);
            end
            DP_DONE:
            begin
                bad_out_reg <= bad;
                final_reg   <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done        = done_reg;
    assign accepted    = acc_reg;
    assign tree_total  = sum_reg;
    assign total_final = final_reg;
    assign bad_node    = bad_out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/union_find_edge_acceptor.sv
// Union-find edge acceptor top level: controller plus datapath.
// Depends on ufea_pkg, ufea_ctrl and ufea_dpath.
//
// Usage: drive node_a, node_b, edge_weight and last_edge with start high; the
// item is taken at a clock edge where start is high and busy is low. Exactly
// one result follows, shown for one cycle with done high: accepted, tree_total
// (saturating 48-bit sum of accepted weights), total_final (copy of last_edge)
// and bad_node. The receiver cannot hold results off. The user must write
// node_count (cfg_write/cfg_data) only while the block is idle; not enforced.
//
// A bad edge skips the walks and goes from the range check to the result.
// For a good edge, each parent chain is walked once to find the root and once
// more to compress it, one memory read per step through the single read port
// of the parent memory. busy drops as done rises, so the next item can be
// taken in the strobe cycle.
//
// Reset: the parent memory is filled with entry i = i by a clearing pass over
// all NODES entries after reset, during which busy is high. The sum clears to
// zero and node_count returns to 1023. last_edge clears no state.
`default_nettype none

module union_find_edge_acceptor
    import ufea_pkg::*;
#(
    parameter int NODES       = NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire [NODE_W-1:0]    node_a,
    input  wire [NODE_W-1:0]    node_b,
    input  wire [WEIGHT_W-1:0]  edge_weight,
    input  wire                 last_edge,
    input  wire                 cfg_write,
    input  wire [NODE_W-1:0]    cfg_data,
    output logic                done,
    output logic                accepted,
    output logic [SUM_W-1:0]    tree_total,
    output logic                total_final,
    output logic                bad_node
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ufea_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ufea_dpath #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .node_a      (node_a),
        .node_b      (node_b),
        .edge_weight (edge_weight),
        .last_edge   (last_edge),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .done        (done),
        .accepted    (accepted),
        .tree_total  (tree_total),
        .total_final (total_final),
        .bad_node    (bad_node)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ufea_checker.sv
// Port-level checks for the union-find edge acceptor, bound to the top level.
// Depends on ufea_pkg and union_find_edge_acceptor.
`default_nettype none

module ufea_checker
    import ufea_pkg::*;
(
    input wire               clk,
    input wire               rst_n,
    input wire               start,
    input wire               busy,
    input wire               done,
    input wire               accepted,
    input wire               bad_node,
    input wire [SUM_W-1:0]   tree_total
);

    // an accepted item keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after taking an item");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_bad_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_node |-> !accepted)
        else $error("bad edge reported as accepted");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (tree_total >= $past(tree_total)))
        else $error("running total went down");

    a_rejected_total: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> $stable(tree_total))
        else $error("total changed on a rejected edge");

endmodule

bind union_find_edge_acceptor ufea_checker u_ufea_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .accepted   (accepted),
    .bad_node   (bad_node),
    .tree_total (tree_total)
);

`default_nettype wire
